// ===== rtl/gmh_pkg.sv =====
// gmh_pkg: shared types and constants for the guide markup to html stream
// used by the front parser, the command queue, the back serializer and top level
package gmh_pkg;

  // reset value of the descramble key
  localparam logic [7:0] KEY_RESET = 8'h1A;

  // configuration register indexes
  localparam logic REG_XOR_KEY = 1'b0;

  // command queue geometry
  localparam int FIFO_AW    = 2;
  localparam int FIFO_DEPTH = 1 << FIFO_AW;

  // kinds of work handed from front to back
  typedef enum logic [2:0] {
    CMD_CHAR = 3'd0,  // one byte, possibly repeated
    CMD_LT   = 3'd1,  // "&lt;"
    CMD_GT   = 3'd2,  // "&gt;"
    CMD_AMP  = 3'd3,  // "&amp;"
    CMD_TAGS = 3'd4   // bold and/or underline tag sequence
  } cmd_op_t;

  // one queued command
  typedef struct packed {
    cmd_op_t    op;
    logic [7:0] ch;
    logic [7:0] rep;
    logic       b_on;
    logic       b_close;
    logic       u_on;
    logic       u_close;
    logic       line_end;
  } cmd_t;

endpackage

// ===== rtl/gmh_front.sv =====
// gmh_front: descrambles each input byte and parses caret markup into commands
// depends on gmh_pkg
module gmh_front import gmh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic [7:0] xor_key,
  output logic       push,
  output cmd_t       cmd
);

  typedef enum logic [2:0] {
    PH_NORMAL = 3'd0,
    PH_CARET  = 3'd1,
    PH_ATTR_H = 3'd2,
    PH_ATTR_L = 3'd3,
    PH_CHAR_H = 3'd4,
    PH_CHAR_L = 3'd5,
    PH_SPACES = 3'd6
  } phase_t;

  phase_t     phase, phase_next;
  logic [3:0] high_nibble, high_nibble_next;
  logic       bold_open, bold_open_next;
  logic       underline_open, underline_open_next;
  logic [7:0] d;

  // hex digit value, anything else counts as zero
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= "0" && c <= "9") v = 4'(c - "0");
    else if (c >= "A" && c <= "F") v = 4'(c - "A" + 8'd10);
    else if (c >= "a" && c <= "f") v = 4'(c - "a" + 8'd10);
    return v;
  endfunction

  // box-drawing to ascii, other unprintables to a dot, zero kept
  function automatic logic [7:0] sane(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'hB3, 8'hB4, 8'hB5, 8'hB6, 8'hB9, 8'hBA, 8'hC3, 8'hCC: r = "|";
      8'hC4, 8'hC1, 8'hC2, 8'hC6, 8'hC7, 8'hCA, 8'hCB, 8'hCD,
      8'hCF, 8'hD0, 8'hD1, 8'hD2: r = "-";
      8'hB7, 8'hB8, 8'hBB, 8'hBC, 8'hBD, 8'hBE, 8'hBF, 8'hC0,
      8'hC5, 8'hC8, 8'hC9, 8'hCE, 8'hD3, 8'hD4, 8'hD5, 8'hD6,
      8'hD7, 8'hD8, 8'hD9, 8'hDA: r = "+";
      8'hDB, 8'hDC, 8'hDD, 8'hDE, 8'hDF, 8'hB0, 8'hB1, 8'hB2: r = "#";
      default: begin
        if (c != 8'h00 && (c < 8'h20 || c > 8'h7E)) r = ".";
        else r = c;
      end
    endcase
    return r;
  endfunction

  // command for one text character with html escaping
  function automatic cmd_t html_cmd(input logic [7:0] c);
    cmd_t r;
    r = '0;
    r.rep = 8'd1;
    case (c)
      "<":     r.op = CMD_LT;
      ">":     r.op = CMD_GT;
      "&":     r.op = CMD_AMP;
      8'h00: begin
        r.op = CMD_CHAR;
        r.ch = " ";
      end
      default: begin
        r.op = CMD_CHAR;
        r.ch = c;
      end
    endcase
    return r;
  endfunction

  assign d = in_byte ^ xor_key;

  // parse one byte
  always_comb begin
    phase_next          = phase;
    high_nibble_next    = high_nibble;
    bold_open_next      = bold_open;
    underline_open_next = underline_open;
    push                = 1'b0;
    cmd                 = '0;
    cmd.op              = CMD_CHAR;
    cmd.rep             = 8'd1;
    if (d == 8'h00) begin
      // end of line closes open tags
      cmd.op              = CMD_TAGS;
      cmd.b_on            = bold_open;
      cmd.b_close         = 1'b1;
      cmd.u_on            = underline_open;
      cmd.u_close         = 1'b1;
      cmd.line_end        = 1'b1;
      push                = bold_open | underline_open;
      bold_open_next      = 1'b0;
      underline_open_next = 1'b0;
      phase_next          = PH_NORMAL;
    end else begin
      case (phase)
        PH_CARET: begin
          phase_next = PH_NORMAL;
          case (d)
            "a", "A": phase_next = PH_ATTR_H;
            "c", "C": phase_next = PH_CHAR_H;
            "b", "B": begin
              cmd.op         = CMD_TAGS;
              cmd.b_on       = 1'b1;
              cmd.b_close    = bold_open;
              push           = 1'b1;
              bold_open_next = ~bold_open;
            end
            "u", "U": begin
              cmd.op              = CMD_TAGS;
              cmd.u_on            = 1'b1;
              cmd.u_close         = underline_open;
              push                = 1'b1;
              underline_open_next = ~underline_open;
            end
            "n", "N": begin
              cmd.op              = CMD_TAGS;
              cmd.b_on            = bold_open;
              cmd.b_close         = 1'b1;
              cmd.u_on            = underline_open;
              cmd.u_close         = 1'b1;
              push                = bold_open | underline_open;
              bold_open_next      = 1'b0;
              underline_open_next = 1'b0;
            end
            "r", "R": ;
            "^": begin
              cmd.ch = "^";
              push   = 1'b1;
            end
            default: begin
              // caret dropped, byte handled as in normal text
              if (d == 8'hFF) begin
                phase_next = PH_SPACES;
              end else begin
                cmd  = html_cmd(sane(d));
                push = 1'b1;
              end
            end
          endcase
        end
        PH_ATTR_H: phase_next = PH_ATTR_L;
        PH_ATTR_L: phase_next = PH_NORMAL;
        PH_CHAR_H: begin
          high_nibble_next = hex_val(d);
          phase_next       = PH_CHAR_L;
        end
        PH_CHAR_L: begin
          phase_next = PH_NORMAL;
          cmd        = html_cmd(sane({high_nibble, hex_val(d)}));
          push       = 1'b1;
        end
        PH_SPACES: begin
          phase_next = PH_NORMAL;
          cmd.ch     = " ";
          cmd.rep    = d;
          push       = 1'b1;
        end
        default: begin
          // normal text
          if (d == "^") begin
            phase_next = PH_CARET;
          end else if (d == 8'hFF) begin
            phase_next = PH_SPACES;
          end else begin
            phase_next = PH_NORMAL;
            cmd        = html_cmd(sane(d));
            push       = 1'b1;
          end
        end
      endcase
    end
    push = push & accept;
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_NORMAL;
      high_nibble    <= 4'd0;
      bold_open      <= 1'b0;
      underline_open <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      high_nibble    <= high_nibble_next;
      bold_open      <= bold_open_next;
      underline_open <= underline_open_next;
    end
  end

endmodule

// ===== rtl/gmh_fifo.sv =====
// gmh_fifo: short command queue between parser and serializer
// depends on gmh_pkg
module gmh_fifo import gmh_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head_cmd,
  output logic full,
  output logic empty
);

  cmd_t                 entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr;
  logic [FIFO_AW-1:0]   rd_ptr;
  logic [FIFO_AW:0]     count;

  assign full     = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty    = (count == '0);
  assign head_cmd = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

endmodule

// ===== rtl/gmh_back.sv =====
// gmh_back: expands queued commands into result bytes behind an output register
// depends on gmh_pkg
module gmh_back import gmh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  cmd_t       head_cmd,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [7:0] repeat_res,
  output logic       last,
  output logic       line_end
);

  cmd_t       work;
  logic       work_valid;
  logic [2:0] idx;
  logic [3:0] len;
  logic [3:0] b_len;
  logic       fin;
  logic       adv;
  logic [7:0] cur_byte;

  // one character of "<X>" or "</X>"
  function automatic logic [7:0] tag_char(input logic cls, input logic [7:0] letter,
                                          input logic [2:0] pos);
    logic [7:0] r;
    r = ">";
    if (cls) begin
      case (pos)
        3'd0:    r = "<";
        3'd1:    r = "/";
        3'd2:    r = letter;
        default: r = ">";
      endcase
    end else begin
      case (pos)
        3'd0:    r = "<";
        3'd1:    r = letter;
        default: r = ">";
      endcase
    end
    return r;
  endfunction

  // length of the current command
  always_comb begin
    b_len = work.b_on ? (work.b_close ? 4'd4 : 4'd3) : 4'd0;
    case (work.op)
      CMD_LT, CMD_GT: len = 4'd4;
      CMD_AMP:        len = 4'd5;
      CMD_TAGS:       len = b_len + (work.u_on ? (work.u_close ? 4'd4 : 4'd3) : 4'd0);
      default:        len = 4'd1;
    endcase
  end

  // byte at the current position
  always_comb begin
    case (work.op)
      CMD_LT: begin
        case (idx)
          3'd0:    cur_byte = "&";
          3'd1:    cur_byte = "l";
          3'd2:    cur_byte = "t";
          default: cur_byte = ";";
        endcase
      end
      CMD_GT: begin
        case (idx)
          3'd0:    cur_byte = "&";
          3'd1:    cur_byte = "g";
          3'd2:    cur_byte = "t";
          default: cur_byte = ";";
        endcase
      end
      CMD_AMP: begin
        case (idx)
          3'd0:    cur_byte = "&";
          3'd1:    cur_byte = "a";
          3'd2:    cur_byte = "m";
          3'd3:    cur_byte = "p";
          default: cur_byte = ";";
        endcase
      end
      CMD_TAGS: begin
        if ({1'b0, idx} < b_len) cur_byte = tag_char(work.b_close, "B", idx);
        else cur_byte = tag_char(work.u_close, "U", 3'(idx - b_len[2:0]));
      end
      default: cur_byte = work.ch;
    endcase
  end

  assign fin = ({1'b0, idx} == len - 4'd1);
  assign adv = ~out_valid | ~out_stall;
  assign pop = head_valid & (~work_valid | (adv & fin));

  // work register and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= work_valid;
        if (work_valid) begin
          out_byte   <= cur_byte;
          repeat_res <= (work.op == CMD_CHAR) ? work.rep : 8'd1;
          last       <= fin;
          line_end   <= work.line_end;
        end
      end
      if (pop) begin
        work       <= head_cmd;
        idx        <= 3'd0;
        work_valid <= 1'b1;
      end else if (adv && work_valid) begin
        if (fin) work_valid <= 1'b0;
        else idx <= idx + 3'd1;
      end
    end
  end

endmodule

// ===== rtl/guide_markup_to_html_stream.sv =====
// guide_markup_to_html_stream: top level, key register, parser, queue, serializer
// depends on gmh_pkg, gmh_front, gmh_fifo, gmh_back
//
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  input    | in_valid, in_stall, in_byte              | in
//  result   | out_valid, out_stall, out_byte,          | out
//           | repeat_res, last, line_end               |
//  config   | psel, penable, pwrite, paddr, pwdata,    | in/out
//           | prdata, pready                           |
//
// one input byte per cycle while the four-entry command queue has room
// escapes and tags expand to 3 to 8 result bytes each at the serializer
// parser to first result passes the queue write, the work register and the output register
// in_stall rises when the queue is full; out_stall holds the output register
// synchronous reset clears parser state, queue and valids; key returns to 0x1A
module guide_markup_to_html_stream import gmh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [7:0]  repeat_res,
  output logic        last,
  output logic        line_end,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] xor_key;
  logic       accept;
  logic       push;
  cmd_t       push_cmd;
  cmd_t       head_cmd;
  logic       pop;
  logic       full;
  logic       empty;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_XOR_KEY) ? {24'd0, xor_key} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      xor_key <= KEY_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_XOR_KEY) begin
      xor_key <= pwdata[7:0];
    end
  end

  // input handshake
  assign in_stall = full;
  assign accept   = in_valid & ~full;

  gmh_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (in_byte),
    .xor_key (xor_key),
    .push    (push),
    .cmd     (push_cmd)
  );

  gmh_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .full     (full),
    .empty    (empty)
  );

  gmh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (~empty),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .repeat_res (repeat_res),
    .last       (last),
    .line_end   (line_end)
  );

endmodule

// ===== rtl/gmh_checker.sv =====
// gmh_checker: port-level assertions for guide_markup_to_html_stream
// bound to the top level; sees only its ports
module gmh_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic [7:0] repeat_res,
  input logic       last,
  input logic       line_end
);

  // a stalled input transaction holds
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_byte))
    else $error("input transaction changed while stalled");

  // a stalled result transaction holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(repeat_res)
      && $stable(last) && $stable(line_end))
    else $error("result transaction changed while stalled");

  // repeat count is never zero
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> repeat_res != 8'd0)
    else $error("zero repeat count");

  // only a space run repeats, and it is a result of its own
  assert property (@(posedge clk) disable iff (rst)
    out_valid && repeat_res != 8'd1 |-> out_byte == 8'h20 && last && !line_end)
    else $error("repeat on a non-space result");

  // end-of-line results are closing tag characters
  assert property (@(posedge clk) disable iff (rst)
    out_valid && line_end |-> repeat_res == 8'd1 && (out_byte == 8'h3C
      || out_byte == 8'h2F || out_byte == 8'h42 || out_byte == 8'h55 || out_byte == 8'h3E))
    else $error("unexpected byte on line end");

endmodule

bind guide_markup_to_html_stream gmh_checker u_gmh_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .in_byte    (in_byte),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_byte   (out_byte),
  .repeat_res (repeat_res),
  .last       (last),
  .line_end   (line_end)
);
